>>> rtl/mtc_pkg.sv
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared types, constants and arithmetic helpers of the motion triggered
// capture unit.
// ----------------------------------------------------------------------------
package mtc_pkg;

  localparam int unsigned CAPTURE_LENGTH = 10;
  localparam int unsigned CNT_W = (CAPTURE_LENGTH > 1) ? $clog2(CAPTURE_LENGTH) : 1;

  localparam int unsigned RAW_W    = 16;
  localparam int unsigned MAG_W    = 17;
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned THR_W    = 23;
  localparam int unsigned SCALED_W = 23;
  localparam int unsigned VAL_W    = 24;
  localparam int unsigned PROD_W   = MAG_W + GAIN_W;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned NUM_AXES = 6;
  localparam int unsigned NUM_ACC  = 3;

  localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST = 24'd80237;
  localparam logic [GAIN_W-1:0] GYRO_GAIN_RST  = 24'd1174405;
  localparam logic [THR_W-1:0]  THRESHOLD_RST  = 23'd1280;

  localparam logic [RAW_W-1:0] HALF_SCALE = 16'h8000;

  typedef enum logic [1:0] {
    CFG_ACCEL_GAIN = 2'd0,
    CFG_GYRO_GAIN  = 2'd1,
    CFG_THRESHOLD  = 2'd2
  } cfg_index_e;

  typedef enum logic {
    OP_DATA      = 1'b0,
    OP_CALIBRATE = 1'b1
  } opcode_e;

  typedef struct packed {
    logic             opcode;
    logic [RAW_W-1:0] accel_x_raw;
    logic [RAW_W-1:0] accel_y_raw;
    logic [RAW_W-1:0] accel_z_raw;
    logic [RAW_W-1:0] rate_x_raw;
    logic [RAW_W-1:0] rate_y_raw;
    logic [RAW_W-1:0] rate_z_raw;
  } in_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] accel_x;
    logic signed [VAL_W-1:0] accel_y;
    logic signed [VAL_W-1:0] accel_z;
    logic signed [VAL_W-1:0] rate_x;
    logic signed [VAL_W-1:0] rate_y;
    logic signed [VAL_W-1:0] rate_z;
    logic [IDX_W-1:0]        sample_index;
    logic                    last_sample;
  } out_res_t;

  // A word above half scale folds back to its distance from full scale.
  function automatic logic [MAG_W-1:0] magnitude(input logic [RAW_W-1:0] w);
    logic [MAG_W-1:0] full;
    full = {1'b1, {RAW_W{1'b0}}};
    if (w > HALF_SCALE) begin
      magnitude = full - {1'b0, w};
    end else begin
      magnitude = {1'b0, w};
    end
  endfunction

  // Gain is in units of 2^-16; keep the integer part of the product.
  function automatic logic [SCALED_W-1:0] scale(input logic [RAW_W-1:0]  w,
                                                input logic [GAIN_W-1:0] gain);
    logic [PROD_W-1:0] prod;
    prod  = PROD_W'(magnitude(w)) * PROD_W'(gain);
    scale = prod[16 +: SCALED_W];
  endfunction

endpackage

>>> rtl/motion_triggered_capture_unit.sv
// ----------------------------------------------------------------------------
// motion_triggered_capture_unit
// Scales six inertial words per request, removes calibrated offsets and emits
// a burst of samples once acceleration crosses the trigger threshold.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i/in_req_i and are taken when in_stall_o is low.
//   A calibrate request stores the six scaled magnitudes as offsets and gives
//   no result. A data request gives a result only while a capture runs or when
//   it starts one. Results leave on out_valid_o/out_res_o and are taken when
//   out_stall_i is low.
//   out_valid_o rises after the stage register and then the result register
//   have taken a request. The six 17x24 gain multiplies sit between the input
//   port and the stage register; offset removal, threshold compare and capture
//   control sit between the stage register and the result register.
//   Throughput is one request per cycle between stalls. in_stall_o rises only
//   when the stage register is full and out_stall_i holds the result register.
//   Registers are written over cfg_valid_i/cfg_index_i/cfg_data_i; cfg_ready_o
//   is always high. Reset empties the pipeline, arms the trigger, zeroes the
//   offsets and loads the default gains and threshold.
// ----------------------------------------------------------------------------
module motion_triggered_capture_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mtc_pkg::in_req_t    in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mtc_pkg::out_res_t   out_res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [23:0]         cfg_data_i
);

  localparam logic [mtc_pkg::CNT_W-1:0] LAST_POS =
    mtc_pkg::CNT_W'(mtc_pkg::CAPTURE_LENGTH - 1);

  logic [mtc_pkg::GAIN_W-1:0] accel_gain_q;
  logic [mtc_pkg::GAIN_W-1:0] gyro_gain_q;
  logic [mtc_pkg::THR_W-1:0]  thr_q;

  logic                                            s1_vld_q;
  logic                                            s1_op_q;
  logic [mtc_pkg::NUM_AXES-1:0][mtc_pkg::SCALED_W-1:0] s1_scaled_q;
  logic [mtc_pkg::NUM_AXES-1:0][mtc_pkg::SCALED_W-1:0] off_q;

  logic                       capt_q, capt_d;
  logic [mtc_pkg::CNT_W-1:0]  cnt_q, cnt_d;

  logic                       out_vld_q, out_vld_d;
  mtc_pkg::out_res_t          out_res_q, out_res_d;

  logic                       in_acc;
  logic                       out_free;
  logic                       s1_go;
  logic                       is_calib;
  logic                       hit;
  logic                       emit;
  logic                       last;
  logic [mtc_pkg::CNT_W-1:0]  pos;
  logic [mtc_pkg::NUM_AXES-1:0][mtc_pkg::VAL_W-1:0] val;
  logic signed [mtc_pkg::VAL_W:0] thr_pos;
  logic signed [mtc_pkg::VAL_W:0] thr_neg;
  logic signed [mtc_pkg::VAL_W:0] v_ext [mtc_pkg::NUM_ACC];

  assign cfg_ready_o = 1'b1;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign s1_go      = s1_vld_q && out_free;
  assign in_stall_o = s1_vld_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_calib   = (s1_op_q == mtc_pkg::OP_CALIBRATE);

  assign thr_pos = $signed({2'b00, thr_q});
  assign thr_neg = -thr_pos;

  always_comb begin
    for (int i = 0; i < mtc_pkg::NUM_AXES; i++) begin
      val[i] = {1'b0, s1_scaled_q[i]} - {1'b0, off_q[i]};
    end
    hit = 1'b0;
    for (int i = 0; i < mtc_pkg::NUM_ACC; i++) begin
      v_ext[i] = $signed({val[i][mtc_pkg::VAL_W-1], val[i]});
      if (v_ext[i] > thr_pos || v_ext[i] < thr_neg) begin
        hit = 1'b1;
      end
    end
    pos  = capt_q ? cnt_q : '0;
    emit = !is_calib && (capt_q || hit);
    last = (pos == LAST_POS);
  end

  always_comb begin
    capt_d = capt_q;
    cnt_d  = cnt_q;
    if (s1_go && emit) begin
      if (last) begin
        capt_d = 1'b0;
        cnt_d  = '0;
      end else begin
        capt_d = 1'b1;
        cnt_d  = pos + mtc_pkg::CNT_W'(1);
      end
    end
  end

  always_comb begin
    if (s1_go) begin
      out_vld_d = emit;
    end else if (out_free) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
    out_res_d.accel_x      = val[0];
    out_res_d.accel_y      = val[1];
    out_res_d.accel_z      = val[2];
    out_res_d.rate_x       = val[3];
    out_res_d.rate_y       = val[4];
    out_res_d.rate_z       = val[5];
    out_res_d.sample_index = mtc_pkg::IDX_W'(pos);
    out_res_d.last_sample  = last;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_gain_q <= mtc_pkg::ACCEL_GAIN_RST;
      gyro_gain_q  <= mtc_pkg::GYRO_GAIN_RST;
      thr_q        <= mtc_pkg::THRESHOLD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mtc_pkg::CFG_ACCEL_GAIN: accel_gain_q <= cfg_data_i;
        mtc_pkg::CFG_GYRO_GAIN:  gyro_gain_q  <= cfg_data_i;
        mtc_pkg::CFG_THRESHOLD:  thr_q        <= cfg_data_i[mtc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state and offsets.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      capt_q    <= 1'b0;
      cnt_q     <= '0;
      off_q     <= '0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_go) begin
        s1_vld_q <= 1'b0;
      end
      out_vld_q <= out_vld_d;
      capt_q    <= capt_d;
      cnt_q     <= cnt_d;
      if (s1_go && is_calib) begin
        off_q <= s1_scaled_q;
      end
    end
  end

  // Payload registers; the gain multiplies happen on the way into stage one.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q        <= in_req_i.opcode;
      s1_scaled_q[0] <= mtc_pkg::scale(in_req_i.accel_x_raw, accel_gain_q);
      s1_scaled_q[1] <= mtc_pkg::scale(in_req_i.accel_y_raw, accel_gain_q);
      s1_scaled_q[2] <= mtc_pkg::scale(in_req_i.accel_z_raw, accel_gain_q);
      s1_scaled_q[3] <= mtc_pkg::scale(in_req_i.rate_x_raw, gyro_gain_q);
      s1_scaled_q[4] <= mtc_pkg::scale(in_req_i.rate_y_raw, gyro_gain_q);
      s1_scaled_q[5] <= mtc_pkg::scale(in_req_i.rate_z_raw, gyro_gain_q);
    end
    if (s1_go && emit) begin
      out_res_q <= out_res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_res_q;

  // The counter is nonzero exactly while a capture is running.
  a_cnt_tracks_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    capt_q == (cnt_q != '0))
    else $error("capture counter out of step with capture flag");

  // A flagged last sample always sits at the final capture position.
  a_last_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.last_sample |->
      out_res_o.sample_index == mtc_pkg::IDX_W'(mtc_pkg::CAPTURE_LENGTH - 1))
    else $error("last sample flagged at wrong position");

  // A calibrate request leaves nothing in the result register.
  a_calib_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && is_calib |=> !out_valid_o)
    else $error("calibrate request produced a result");

  // Backpressure only comes from a full stage held by a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_vld_q && out_vld_q && out_stall_i)
    else $error("input stalled without a blocked result");

endmodule

>>> test/tb_motion_triggered_capture_unit.sv
// ----------------------------------------------------------------------------
// tb_motion_triggered_capture_unit
// Drives raw inertial requests and register writes into the capture unit and
// checks every emitted sample, field by field, against an in-bench model of
// the scaling, offset removal and threshold triggered burst capture.
// ----------------------------------------------------------------------------
module tb_motion_triggered_capture_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STUCK_LIMIT = 4000;
  localparam int unsigned NUM_ROUNDS  = 9;
  localparam int unsigned ROUND_ITEMS = 195;

  typedef struct {
    bit                typed;
    bit                yields;
    mtc_pkg::in_req_t  req;
    mtc_pkg::out_res_t res;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  mtc_pkg::in_req_t  in_req_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  mtc_pkg::out_res_t out_res_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i = '0;
  logic [23:0]       cfg_data_i  = '0;

  motion_triggered_capture_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Model state, starting from the reset values of the block.
  logic [mtc_pkg::GAIN_W-1:0]   cur_accel_gain = mtc_pkg::ACCEL_GAIN_RST;
  logic [mtc_pkg::GAIN_W-1:0]   cur_gyro_gain  = mtc_pkg::GYRO_GAIN_RST;
  logic [mtc_pkg::THR_W-1:0]    cur_threshold  = mtc_pkg::THRESHOLD_RST;
  bit                           in_capture     = 1'b0;
  int unsigned                  capture_pos    = 0;
  logic [mtc_pkg::SCALED_W-1:0] axis_offset [mtc_pkg::NUM_AXES] = '{default: '0};

  mtc_pkg::out_res_t pending_samples [$];
  int unsigned mismatch_count = 0;
  int unsigned stuck_cycles   = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;

  // Set by the stimulus loop for directed rows whose result is typed in.
  bit                row_typed  = 1'b0;
  bit                row_yields = 1'b0;
  mtc_pkg::out_res_t row_res    = '0;

  mtc_pkg::out_res_t mon_expected;
  mtc_pkg::out_res_t mon_predicted;
  bit                mon_yields;
  bit                mon_accepted;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [mtc_pkg::SCALED_W-1:0] scaled_magnitude(
      input logic [mtc_pkg::RAW_W-1:0]  word,
      input logic [mtc_pkg::GAIN_W-1:0] gain);
    logic [16:0] mag;
    logic [40:0] prod;
    mag  = (word > 16'd32768) ? (17'd65536 - 17'(word)) : 17'(word);
    prod = 41'(mag) * 41'(gain);
    return prod[38:16];
  endfunction

  function automatic bit predict_capture(input mtc_pkg::in_req_t req,
                                         output mtc_pkg::out_res_t res);
    logic [mtc_pkg::RAW_W-1:0]    raw [mtc_pkg::NUM_AXES];
    logic [mtc_pkg::SCALED_W-1:0] scl [mtc_pkg::NUM_AXES];
    int                           val [mtc_pkg::NUM_AXES];
    int                           thr;
    bit                           hit;
    bit                           last_one;
    int unsigned                  pos;
    raw = '{req.accel_x_raw, req.accel_y_raw, req.accel_z_raw,
            req.rate_x_raw, req.rate_y_raw, req.rate_z_raw};
    res = '0;
    for (int i = 0; i < mtc_pkg::NUM_AXES; i++) begin
      scl[i] = scaled_magnitude(raw[i],
                                (i < mtc_pkg::NUM_ACC) ? cur_accel_gain : cur_gyro_gain);
    end
    if (mtc_pkg::opcode_e'(req.opcode) == mtc_pkg::OP_CALIBRATE) begin
      for (int i = 0; i < mtc_pkg::NUM_AXES; i++) begin
        axis_offset[i] = scl[i];
      end
      return 1'b0;
    end
    for (int i = 0; i < mtc_pkg::NUM_AXES; i++) begin
      val[i] = int'(scl[i]) - int'(axis_offset[i]);
    end
    if (!in_capture) begin
      thr = int'(cur_threshold);
      hit = 1'b0;
      for (int i = 0; i < mtc_pkg::NUM_ACC; i++) begin
        if (val[i] > thr || val[i] < -thr) hit = 1'b1;
      end
      if (!hit) return 1'b0;
      pos = 0;
    end else begin
      pos = capture_pos;
    end
    last_one    = (pos + 1 >= mtc_pkg::CAPTURE_LENGTH);
    in_capture  = !last_one;
    capture_pos = last_one ? 0 : pos + 1;
    res.accel_x      = val[0][23:0];
    res.accel_y      = val[1][23:0];
    res.accel_z      = val[2][23:0];
    res.rate_x       = val[3][23:0];
    res.rate_y       = val[4][23:0];
    res.rate_z       = val[5][23:0];
    res.sample_index = pos[3:0];
    res.last_sample  = last_one;
    return 1'b1;
  endfunction

  task automatic compare_field(input string field, input logic signed [23:0] want,
                               input logic signed [23:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  // Everything is sampled at the rising edge, before the block's own updates.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      mon_accepted = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        mon_accepted = 1'b1;
        case (mtc_pkg::cfg_index_e'(cfg_index_i))
          mtc_pkg::CFG_ACCEL_GAIN: cur_accel_gain = cfg_data_i;
          mtc_pkg::CFG_GYRO_GAIN:  cur_gyro_gain  = cfg_data_i;
          mtc_pkg::CFG_THRESHOLD:  cur_threshold  = cfg_data_i[mtc_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        mon_accepted = 1'b1;
        mon_yields = predict_capture(in_req_i, mon_predicted);
        if (row_typed) begin
          mon_yields    = row_yields;
          mon_predicted = row_res;
        end
        if (mon_yields) pending_samples.push_back(mon_predicted);
      end
      if (out_valid_o && !out_stall_i) begin
        mon_accepted = 1'b1;
        if (pending_samples.size() == 0) begin
          mismatch_count++;
          $display("%0t: result expected none actual %p", $time, out_res_o);
        end else begin
          mon_expected = pending_samples.pop_front();
          compare_field("accel_x", mon_expected.accel_x, out_res_o.accel_x);
          compare_field("accel_y", mon_expected.accel_y, out_res_o.accel_y);
          compare_field("accel_z", mon_expected.accel_z, out_res_o.accel_z);
          compare_field("rate_x", mon_expected.rate_x, out_res_o.rate_x);
          compare_field("rate_y", mon_expected.rate_y, out_res_o.rate_y);
          compare_field("rate_z", mon_expected.rate_z, out_res_o.rate_z);
          compare_field("sample_index", 24'(mon_expected.sample_index),
                        24'(out_res_o.sample_index));
          compare_field("last_sample", 24'(mon_expected.last_sample),
                        24'(out_res_o.last_sample));
        end
      end
      stuck_cycles = mon_accepted ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
        $display("tb_motion_triggered_capture_unit: errors");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(input mtc_pkg::in_req_t req);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_req_i   <= req;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
  endtask

  // Waits out every pending sample plus the pipeline depth, so that the
  // last requests that give no result have left the block too.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_regs(input logic [mtc_pkg::GAIN_W-1:0] accel_gain,
                            input logic [mtc_pkg::GAIN_W-1:0] gyro_gain,
                            input logic [mtc_pkg::THR_W-1:0]  threshold);
    mtc_pkg::cfg_index_e idx_list [3];
    logic [23:0]         data_list [3];
    idx_list  = '{mtc_pkg::CFG_ACCEL_GAIN, mtc_pkg::CFG_GYRO_GAIN, mtc_pkg::CFG_THRESHOLD};
    data_list = '{accel_gain, gyro_gain, 24'(threshold)};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx_list[i];
      cfg_data_i  <= data_list[i];
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic mtc_pkg::in_req_t make_request(
      input mtc_pkg::opcode_e op,
      input logic [mtc_pkg::RAW_W-1:0] ax, ay, az, rx, ry, rz);
    mtc_pkg::in_req_t r;
    r = '{op, ax, ay, az, rx, ry, rz};
    return r;
  endfunction

  // Random words, with corner words, folded negatives and near-trigger values.
  function automatic logic [mtc_pkg::RAW_W-1:0] random_word();
    logic [mtc_pkg::RAW_W-1:0] w;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(5))
          0:       w = 16'h0000;
          1:       w = 16'h0001;
          2:       w = 16'h7FFF;
          3:       w = 16'h8000;
          4:       w = 16'h8001;
          default: w = 16'hFFFF;
        endcase
      end
      1, 2:    w = 16'($urandom_range(1200));
      3:       w = 16'h0000 - 16'($urandom_range(1200, 1));
      default: w = 16'($urandom);
    endcase
    return w;
  endfunction

  function automatic logic [mtc_pkg::RAW_W-1:0] quiet_word();
    logic [mtc_pkg::RAW_W-1:0] w;
    w = 16'($urandom_range(900));
    if ($urandom_range(1)) w = 16'h0000 - w;
    return w;
  endfunction

  // Quiet data keeps the trigger armed long enough for real crossings to
  // matter; calibrations at rest are spread through the stream.
  function automatic mtc_pkg::in_req_t random_request();
    mtc_pkg::in_req_t r;
    int unsigned      roll;
    roll = $urandom_range(99);
    r.opcode      = (roll < 6) ? mtc_pkg::OP_CALIBRATE : mtc_pkg::OP_DATA;
    r.accel_x_raw = (roll < 50) ? quiet_word() : random_word();
    r.accel_y_raw = (roll < 50) ? quiet_word() : random_word();
    r.accel_z_raw = (roll < 50) ? quiet_word() : random_word();
    r.rate_x_raw  = random_word();
    r.rate_y_raw  = random_word();
    r.rate_z_raw  = random_word();
    return r;
  endfunction

  initial begin
    stim_row_t                  rows [$];
    mtc_pkg::out_res_t          res;
    logic [mtc_pkg::GAIN_W-1:0] ag;
    logic [mtc_pkg::GAIN_W-1:0] gg;
    logic [mtc_pkg::THR_W-1:0]  thr;

    // Directed rows at the reset register values.
    rows.push_back('{1'b1, 1'b0, make_request(mtc_pkg::OP_DATA, 0, 0, 0, 0, 0, 0), '0});
    res = '0;
    res.accel_x = 24'sd40118;
    rows.push_back('{1'b1, 1'b1,
                     make_request(mtc_pkg::OP_DATA, 16'h8000, 0, 0, 0, 0, 0), res});
    for (int k = 1; k < mtc_pkg::CAPTURE_LENGTH; k++) begin
      res = '0;
      res.sample_index = mtc_pkg::IDX_W'(k);
      res.last_sample  = (k == mtc_pkg::CAPTURE_LENGTH - 1);
      rows.push_back('{1'b1, 1'b1, make_request(mtc_pkg::OP_DATA, 0, 0, 0, 0, 0, 0), res});
    end
    // A magnitude of 1046 scales exactly onto the default threshold.
    rows.push_back('{1'b0, 1'b0,
                     make_request(mtc_pkg::OP_DATA, 16'd1046, 0, 0, 0, 0, 0), '0});
    rows.push_back('{1'b0, 1'b0,
                     make_request(mtc_pkg::OP_DATA, 16'd64490, 0, 0, 0, 0, 0), '0});
    rows.push_back('{1'b0, 1'b0,
                     make_request(mtc_pkg::OP_CALIBRATE, 16'd1046, 0, 0, 0, 0, 0), '0});
    rows.push_back('{1'b0, 1'b0, make_request(mtc_pkg::OP_DATA, 0, 0, 0, 0, 0, 0), '0});
    rows.push_back('{1'b0, 1'b0,
                     make_request(mtc_pkg::OP_CALIBRATE, 16'd1047, 16'hFFFF, 16'h8001,
                                  16'h7FFF, 16'h8000, 16'h0001), '0});
    rows.push_back('{1'b0, 1'b0, make_request(mtc_pkg::OP_DATA, 0, 0, 0, 0, 0, 0), '0});
    // Calibration in the middle of a running capture.
    rows.push_back('{1'b0, 1'b0,
                     make_request(mtc_pkg::OP_CALIBRATE, 16'h8000, 16'h8000, 16'h8000,
                                  16'h8000, 16'h8000, 16'h8000), '0});
    rows.push_back('{1'b0, 1'b0,
                     make_request(mtc_pkg::OP_DATA, 16'hFFFF, 16'h0001, 16'h8001,
                                  16'hFFFF, 16'h7FFF, 16'h8000), '0});
    rows.push_back('{1'b0, 1'b0,
                     make_request(mtc_pkg::OP_CALIBRATE, 0, 0, 0, 0, 0, 0), '0});
    rows.push_back('{1'b0, 1'b0,
                     make_request(mtc_pkg::OP_DATA, 16'h5555, 16'hAAAA, 16'hFFFF,
                                  16'h0000, 16'h1234, 16'hFEDC), '0});

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    src_idle_pct   = 11;
    sink_stall_pct = 86;
    foreach (rows[k]) begin
      row_typed  = rows[k].typed;
      row_yields = rows[k].yields;
      row_res    = rows[k].res;
      send_req(rows[k].req);
    end
    row_typed = 1'b0;

    for (int round = 0; round < NUM_ROUNDS; round++) begin
      drain_block();
      src_idle_pct   = (round < 3) ? 11 : (round < 6) ? 86 : 0;
      sink_stall_pct = (round < 3) ? 86 : (round < 6) ? 11 : 0;
      case (round)
        0: begin
          ag  = mtc_pkg::ACCEL_GAIN_RST;
          gg  = mtc_pkg::GYRO_GAIN_RST;
          thr = mtc_pkg::THRESHOLD_RST;
        end
        1: begin
          ag = '1; gg = '1; thr = mtc_pkg::THR_W'($urandom_range(4095));
        end
        2: begin
          ag = '0; gg = '0; thr = '0;
        end
        3: begin
          ag = mtc_pkg::ACCEL_GAIN_RST; gg = mtc_pkg::GYRO_GAIN_RST; thr = '1;
        end
        default: begin
          ag  = mtc_pkg::GAIN_W'($urandom_range(200000, 20000));
          gg  = mtc_pkg::GAIN_W'($urandom);
          thr = mtc_pkg::THR_W'($urandom_range(3000));
        end
      endcase
      write_regs(ag, gg, thr);
      repeat (ROUND_ITEMS) send_req(random_request());
    end

    drain_block();
    if (mismatch_count == 0) begin
      $display("tb_motion_triggered_capture_unit: clean");
    end else begin
      $display("tb_motion_triggered_capture_unit: errors");
    end
    $finish;
  end

endmodule
